// ===== rtl/rsf_pkg.sv =====
// Package for the RTU silence framer: word types, item kinds, line phases.
// No dependencies; imported by rsf_ctrl, rtu_silence_framer and rsf_checker.
package rsf_pkg;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned GAP_W    = 16;
  localparam int unsigned REQ_W    = 10;
  localparam int unsigned CNT_OUT_W = 9;

  localparam logic [GAP_W-1:0] SHORT_GAP_RESET = 16'd2000;
  localparam logic [GAP_W-1:0] LONG_GAP_RESET  = 16'd3000;
  localparam logic [REQ_W-1:0] TX_LIMIT        = 10'd256;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT_GAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_GAP  = 2'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK    = 3'd0,
    KIND_BYTE    = 3'd1,
    KIND_READ    = 3'd2,
    KIND_RELEASE = 3'd3,
    KIND_XMIT    = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    PH_INIT = 3'd0,
    PH_IDLE = 3'd1,
    PH_RECV = 3'd2,
    PH_CTRL = 3'd3,
    PH_EMIT = 3'd4,
    PH_BAD  = 3'd5
  } phase_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [7:0]        rx_byte;
    logic [7:0]        byte_index;
    logic [REQ_W-1:0]  request_count;
  } in_word_t;

  typedef struct packed {
    logic [7:0]           data_out;
    logic [CNT_OUT_W-1:0] granted_count;
    logic                 accepted;
    logic [CNT_OUT_W-1:0] frame_length;
    logic                 frame_ready;
    logic                 tx_clear;
    logic [2:0]           line_state;
  } out_word_t;

endpackage

// ===== rtl/rsf_store.sv =====
// Frame byte store: one write port, one registered read port.
// Depends on nothing outside this file.
module rsf_store #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rsf_ctrl.sv =====
// Framer control: gap timer, line phase, frame count, config registers, result word.
// Depends on rsf_pkg; drives the store ports of rsf_store.
module rsf_ctrl import rsf_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 256,
  parameter int unsigned AW          = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [GAP_W-1:0]     cfg_data_i,
  input  logic                 fire_i,
  input  in_word_t             word_i,
  output logic                 we_o,
  output logic [AW-1:0]        waddr_o,
  output logic [7:0]           wdata_o,
  output logic                 re_o,
  output logic [AW-1:0]        raddr_o,
  output out_word_t            res_o,
  output logic                 hit_o
);

  localparam int unsigned CW = $clog2(FRAME_BYTES + 1);
  localparam int unsigned MW = (CW > REQ_W) ? CW : REQ_W;
  localparam logic [CW-1:0] FB_C  = CW'(FRAME_BYTES);
  localparam logic [MW-1:0] FB_MW = MW'(FRAME_BYTES);

  logic [GAP_W-1:0] short_q, long_q;
  phase_e           phase_q, phase_d, ph_s;
  logic [GAP_W-1:0] cnt_q, cnt_d, cnt_inc;
  logic             ton_q, ton_d;
  logic [CW-1:0]    stored_q, stored_d;
  logic             done_q, done_d;
  logic             cts_q, cts_d;
  logic [MW-1:0]    granted, req_ext, st_ext, idx_ext;
  logic             acc, hit;
  out_word_t        res_d, res_q;
  logic             hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q <= SHORT_GAP_RESET;
      long_q  <= LONG_GAP_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_SHORT_GAP) short_q <= cfg_data_i;
      if (cfg_index_i == REG_LONG_GAP)  long_q  <= cfg_data_i;
    end
  end

  assign req_ext = MW'(word_i.request_count);
  assign st_ext  = MW'(stored_q);
  assign idx_ext = MW'(word_i.byte_index);
  assign cnt_inc = cnt_q + GAP_W'(1);

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    ton_d    = ton_q;
    stored_d = stored_q;
    done_d   = done_q;
    cts_d    = cts_q;
    granted  = '0;
    acc      = 1'b0;
    hit      = 1'b0;
    we_o     = 1'b0;
    re_o     = 1'b0;
    ph_s     = phase_q;
    if (fire_i) begin
      unique case (kind_e'(word_i.kind))
        KIND_TICK: begin
          if (ton_q) begin
            cnt_d = cnt_inc;
            if (cnt_inc == short_q && phase_q == PH_RECV) ph_s = PH_CTRL;
            phase_d = ph_s;
            if (cnt_inc == long_q) begin
              cnt_d = '0;
              ton_d = 1'b0;
              if (ph_s == PH_INIT || ph_s == PH_EMIT || ph_s == PH_BAD) begin
                if (ph_s == PH_BAD) stored_d = '0;
                phase_d = PH_IDLE;
                cts_d   = 1'b1;
              end else if (ph_s == PH_CTRL) begin
                phase_d = PH_IDLE;
                cts_d   = 1'b1;
                done_d  = 1'b1;
              end
            end
          end
        end
        KIND_BYTE: begin
          if (!done_q) begin
            if (phase_q == PH_CTRL) begin
              phase_d = PH_BAD;
            end else if (phase_q == PH_IDLE || phase_q == PH_RECV) begin
              if (stored_q < FB_C) begin
                we_o     = 1'b1;
                stored_d = stored_q + CW'(1);
              end
              phase_d = PH_RECV;
              cts_d   = 1'b0;
              cnt_d   = '0;
              ton_d   = 1'b1;
            end
          end
        end
        KIND_READ: begin
          if (done_q) begin
            granted = (req_ext < st_ext) ? req_ext : st_ext;
            acc     = 1'b1;
            hit     = (idx_ext < granted) && (idx_ext < FB_MW);
            re_o    = 1'b1;
          end
        end
        KIND_RELEASE: begin
          if (done_q) begin
            stored_d = '0;
            done_d   = 1'b0;
            acc      = 1'b1;
          end
        end
        KIND_XMIT: begin
          if (cts_q) begin
            granted = (word_i.request_count < TX_LIMIT) ? req_ext : MW'(TX_LIMIT);
            acc     = 1'b1;
            cnt_d   = '0;
            ton_d   = 1'b1;
          end
        end
        default: ;
      endcase
    end
    res_d.data_out      = '0;
    res_d.granted_count = granted[CNT_OUT_W-1:0];
    res_d.accepted      = acc;
    res_d.frame_length  = CNT_OUT_W'(stored_d);
    res_d.frame_ready   = done_d;
    res_d.tx_clear      = cts_d;
    res_d.line_state    = 3'(phase_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_INIT;
      cnt_q    <= '0;
      ton_q    <= 1'b1;
      stored_q <= '0;
      done_q   <= 1'b0;
      cts_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      ton_q    <= ton_d;
      stored_q <= stored_d;
      done_q   <= done_d;
      cts_q    <= cts_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      res_q <= res_d;
      hit_q <= hit;
    end
  end

  // reads need frame_ready, which blocks writes, so no same-entry overlap
  assign waddr_o = stored_q[AW-1:0];
  assign wdata_o = word_i.rx_byte;
  assign raddr_o = AW'(word_i.byte_index);
  assign res_o   = res_q;
  assign hit_o   = hit_q;

endmodule

// ===== rtl/rtu_silence_framer.sv =====
// RTU silence framer top level: splits a serial byte stream into frames by line silence.
// Each accepted word's result word is registered and shows in the output register in the cycle after acceptance.
// Throughput: one word per cycle while the output is not stalled; at most one store access (write or read) per word.
// Reset: asynchronous, active low; phase init, timer running, no frame, gaps 2000/3000.
// The frame store is not cleared; only written entries ever reach data_out.
// Depends on rsf_pkg, rsf_ctrl, rsf_store.
module rtu_silence_framer import rsf_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_word_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_word_t            out_word_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [GAP_W-1:0]     cfg_data_i
);

  localparam int unsigned AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

  logic          fire, we, re, hit, out_valid_q;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;
  out_word_t     res;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign fire        = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  rsf_ctrl #(
    .FRAME_BYTES(FRAME_BYTES),
    .AW         (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .word_i     (in_word_i),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .re_o       (re),
    .raddr_o    (raddr),
    .res_o      (res),
    .hit_o      (hit)
  );

  rsf_store #(
    .DEPTH(FRAME_BYTES),
    .AW   (AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_comb begin
    out_word_o          = res;
    out_word_o.data_out = hit ? rdata : 8'd0;
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/rsf_checker.sv =====
// Port-level checks for rtu_silence_framer, bound to the top level.
// Depends on rsf_pkg.
module rsf_checker import rsf_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  a_one_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted word gave no result next cycle");

  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output register");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.frame_ready |->
      out_word_o.tx_clear && out_word_o.line_state == 3'(PH_IDLE))
    else $error("frame ready outside idle clear line");

  a_data_granted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.data_out != 8'd0 |->
      out_word_o.accepted && out_word_o.frame_ready)
    else $error("read data without a granted read");

endmodule

bind rtu_silence_framer rsf_checker u_rsf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_word_o (out_word_o)
);
